// ===== rtl/hex_cell_trilinear_displacement_unit_macros.svh =====
// assertion macros for the displacement unit rtl
`ifndef HEX_CELL_TRILINEAR_DISPLACEMENT_UNIT_MACROS_SVH
`define HEX_CELL_TRILINEAR_DISPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HCTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hctd_pkg.sv =====
// types, constants and saturation helpers for the displacement unit
`default_nettype none

package hctd_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned AXES    = 3;

  // corner numbers with a special role
  localparam logic [2:0] CORNER_ORIGIN = 3'd0;
  localparam logic [2:0] CORNER_EDGE   = 3'd1;
  localparam logic [2:0] CORNER_LAST   = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [SUM_W:0]     wide_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic       start;
    logic       clear;
    logic [2:0] corner;
  } mac_ctrl_t;

  // saturate a 49-bit value to a 32-bit coordinate
  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if ((&v[SUM_W:COORD_W-1]) || !(|v[SUM_W:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // saturate a 49-bit value to the 48-bit accumulator range
  function automatic sum_t sat_sum(input wide_t v);
    sum_t r;
    if (v[SUM_W] == v[SUM_W-1]) begin
      r = v[SUM_W-1:0];
    end else if (v[SUM_W]) begin
      r = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hctd_div.sv =====
// serial restoring divider giving one weight fraction bit per cycle
`default_nettype none

module hctd_div import hctd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [COORD_W-1:0]   num_i,
  input  logic [COORD_W-1:0]   den_i,
  output logic                 done_o,
  output logic [FRAC_BITS-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

  logic                 active_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [COORD_W-1:0]   rem_q;
  logic [COORD_W-1:0]   den_q;
  logic [FRAC_BITS-1:0] quot_q;

  logic [COORD_W:0]     trial;
  logic [COORD_W:0]     diff;
  logic                 fits;

  // one shift-compare-subtract step; remainder stays below the divisor
  always_comb begin
    trial = {rem_q, 1'b0};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        if (cnt_q == LAST_STEP) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (active_q) begin
      rem_q  <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/hctd_mac.sv =====
// shared multiplier: corner weight product then weighted displacement accumulate
`default_nettype none

module hctd_mac import hctd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  coord_t             disp_i   [AXES],
  input  logic [FRAC_BITS:0] weight_i [AXES],
  output logic               done_o,
  output sum_t               sum_o    [AXES]
);

  localparam int unsigned WW     = FRAC_BITS + 1;
  localparam int unsigned PW     = COORD_W + 1 + WW + 1;
  localparam int unsigned PART_W = PW - FRAC_BITS;
  localparam logic [WW-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  // phase codes of one corner
  localparam logic [2:0] PH_FXY  = 3'd0;
  localparam logic [2:0] PH_FZ   = 3'd1;
  localparam logic [2:0] PH_DX   = 3'd2;
  localparam logic [2:0] PH_DY   = 3'd3;
  localparam logic [2:0] PH_DZ   = 3'd4;
  localparam logic [2:0] PH_ACCZ = 3'd5;

  logic                 active_q;
  logic                 done_q;
  logic [2:0]           phase_q;
  logic [2:0]           corner_q;
  coord_t               disp_q [AXES];
  logic signed [PW-1:0] prod_q;
  logic [WW-1:0]        cw_q;
  sum_t                 sum_q  [AXES];

  logic [WW-1:0]          factor [AXES];
  logic [WW-1:0]          cw_now;
  logic signed [COORD_W:0] op_a;
  logic [WW-1:0]          op_b;
  logic signed [WW:0]     op_b_s;
  logic signed [PW-1:0]   prod_d;
  logic [PART_W-1:0]      part;
  logic [1:0]             acc_ax;
  wide_t                  acc;

  // per-axis factor: weight on the high side, one minus weight on the low side
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      factor[i] = corner_q[AXES-1-i] ? weight_i[i] : ONE_W - weight_i[i];
    end
  end

  assign cw_now = prod_q[2*FRAC_BITS:FRAC_BITS];

  // operand selection for the one multiplier
  always_comb begin
    unique case (phase_q)
      PH_FXY: begin
        op_a = {{(COORD_W+1-WW){1'b0}}, factor[0]};
        op_b = factor[1];
      end
      PH_FZ: begin
        op_a = {{(COORD_W+1-WW){1'b0}}, cw_now};
        op_b = factor[2];
      end
      PH_DX: begin
        op_a = {disp_q[0][COORD_W-1], disp_q[0]};
        op_b = cw_now;
      end
      PH_DY: begin
        op_a = {disp_q[1][COORD_W-1], disp_q[1]};
        op_b = cw_q;
      end
      PH_DZ: begin
        op_a = {disp_q[2][COORD_W-1], disp_q[2]};
        op_b = cw_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    op_b_s = {1'b0, op_b};
    prod_d = op_a * op_b_s;
  end

  // floor-shifted contribution added to the axis a phase behind the multiplier
  always_comb begin
    part   = prod_q[PW-1:FRAC_BITS];
    acc_ax = 2'(phase_q - PH_DY);
    acc    = {sum_q[acc_ax][SUM_W-1], sum_q[acc_ax]}
           + {{(SUM_W+1-PART_W){part[PART_W-1]}}, part};
  end

  // phase control and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      phase_q  <= PH_FXY;
      for (int i = 0; i < AXES; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.clear) begin
        for (int i = 0; i < AXES; i++) begin
          sum_q[i] <= '0;
        end
      end
      if (ctrl_i.start) begin
        active_q <= 1'b1;
        phase_q  <= PH_FXY;
      end else if (active_q) begin
        if (phase_q >= PH_DY) begin
          sum_q[acc_ax] <= sat_sum(acc);
        end
        if (phase_q == PH_ACCZ) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          phase_q <= phase_q + 1'b1;
        end
      end
    end
  end

  // operand capture and product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      corner_q <= ctrl_i.corner;
      disp_q   <= disp_i;
    end else if (active_q) begin
      prod_q <= prod_d;
      if (phase_q == PH_DX) begin
        cw_q <= cw_now;
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

// ===== rtl/hex_cell_trilinear_displacement_unit.sv =====
// Trilinear displacement of a query point over one hexahedral cell. Corners are
// fed one item at a time (start high while busy is low); corner 0 carries the
// query point and cell origin and is absorbed without leaving idle. Corners 2..6
// each pass through the shared multiplier (two products for the corner weight,
// one per axis for the displacement); corner 7 does the same and then registers
// the result. Corner 1 first finds the three axis weights, each by the serial
// divider when the query lies strictly inside the edge and directly otherwise,
// then adds corner 0 and itself. After corner 7 the result is shown for exactly
// one cycle on out_valid_o, in the first cycle that busy is low again; the
// receiver cannot stall it and must take it in that cycle.
`default_nettype none
`include "hex_cell_trilinear_displacement_unit_macros.svh"

module hex_cell_trilinear_displacement_unit import hctd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  corner_i,
  input  coord_t      query_x_i,
  input  coord_t      query_y_i,
  input  coord_t      query_z_i,
  input  coord_t      rest_x_i,
  input  coord_t      rest_y_i,
  input  coord_t      rest_z_i,
  input  coord_t      moved_x_i,
  input  coord_t      moved_y_i,
  input  coord_t      moved_z_i,
  output logic        out_valid_o,
  output coord_t      out_x_o,
  output coord_t      out_y_o,
  output coord_t      out_z_o,
  output logic        degenerate_o
);

  localparam int unsigned WW = FRAC_BITS + 1;
  localparam logic [WW-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  // sequencer states
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_AXIS       = 3'd1;
  localparam logic [2:0] S_DIV        = 3'd2;
  localparam logic [2:0] S_MAC_FIRST  = 3'd3;
  localparam logic [2:0] S_WAIT_FIRST = 3'd4;
  localparam logic [2:0] S_MAC_OWN    = 3'd5;
  localparam logic [2:0] S_WAIT_OWN   = 3'd6;
  localparam logic [2:0] S_OUT        = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [1:0]      axis_q, axis_d;
  coord_t          query_q  [AXES];
  coord_t          origin_q [AXES];
  coord_t          fcs_q    [AXES];
  logic [WW-1:0]   weight_q [AXES];
  logic [WW-1:0]   weight_d [AXES];
  logic            bad_q, bad_d;
  logic [2:0]      corner_q;
  coord_t          disp_q   [AXES];
  logic signed [COORD_W:0] h_q;
  logic            out_valid_q;
  coord_t          out_q    [AXES];
  logic            out_bad_q;

  coord_t          query_in [AXES];
  coord_t          rest_in  [AXES];
  coord_t          moved_in [AXES];
  coord_t          disp_in  [AXES];
  logic signed [COORD_W:0] disp_diff [AXES];
  logic            accept;
  logic signed [COORD_W:0] d_axis;
  logic            h_nonpos;
  logic            div_go;
  logic            div_done;
  logic [FRAC_BITS-1:0] div_quot;
  mac_ctrl_t       mac_ctrl;
  coord_t          mac_disp [AXES];
  logic            mac_done;
  sum_t            sum      [AXES];
  wide_t           out_wide [AXES];

  assign accept = start && !busy;

  // item fields as per-axis vectors, displacement saturated to 32 bits
  always_comb begin
    query_in[0] = query_x_i;
    query_in[1] = query_y_i;
    query_in[2] = query_z_i;
    rest_in[0]  = rest_x_i;
    rest_in[1]  = rest_y_i;
    rest_in[2]  = rest_z_i;
    moved_in[0] = moved_x_i;
    moved_in[1] = moved_y_i;
    moved_in[2] = moved_z_i;
    for (int i = 0; i < AXES; i++) begin
      disp_diff[i] = {moved_in[i][COORD_W-1], moved_in[i]}
                   - {rest_in[i][COORD_W-1], rest_in[i]};
      disp_in[i]   = sat_coord({{(SUM_W-COORD_W){disp_diff[i][COORD_W]}}, disp_diff[i]});
    end
  end

  // offset of the query from the origin on the axis being weighted
  always_comb begin
    d_axis   = {query_q[axis_q][COORD_W-1], query_q[axis_q]}
             - {origin_q[axis_q][COORD_W-1], origin_q[axis_q]};
    h_nonpos = h_q[COORD_W] || (h_q == '0);
    div_go   = (state_q == S_AXIS) && !h_nonpos && !d_axis[COORD_W]
             && (d_axis != '0) && (d_axis < h_q);
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    weight_d = weight_q;
    bad_d    = bad_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (corner_i == CORNER_ORIGIN) begin
            for (int i = 0; i < AXES; i++) begin
              weight_d[i] = '0;
            end
            bad_d = 1'b0;
          end else if (corner_i == CORNER_EDGE) begin
            state_d = S_AXIS;
            axis_d  = '0;
          end else begin
            state_d = S_MAC_OWN;
          end
        end
      end
      S_AXIS: begin
        if (h_nonpos) begin
          for (int i = 0; i < AXES; i++) begin
            weight_d[i] = '0;
          end
          bad_d   = 1'b1;
          state_d = S_MAC_FIRST;
        end else begin
          bad_d = 1'b0;
          if (div_go) begin
            state_d = S_DIV;
          end else begin
            weight_d[axis_q] = (d_axis[COORD_W] || d_axis == '0) ? '0 : ONE_W;
            if (axis_q == 2'(AXES - 1)) begin
              state_d = S_MAC_FIRST;
            end else begin
              axis_d = axis_q + 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          weight_d[axis_q] = {1'b0, div_quot};
          if (axis_q == 2'(AXES - 1)) begin
            state_d = S_MAC_FIRST;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_AXIS;
          end
        end
      end
      S_MAC_FIRST: state_d = S_WAIT_FIRST;
      S_WAIT_FIRST: begin
        if (mac_done) begin
          state_d = S_MAC_OWN;
        end
      end
      S_MAC_OWN: state_d = S_WAIT_OWN;
      S_WAIT_OWN: begin
        if (mac_done) begin
          state_d = (corner_q == CORNER_LAST) ? S_OUT : S_IDLE;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control to the multiply-accumulate unit
  always_comb begin
    mac_ctrl.start  = (state_q == S_MAC_FIRST) || (state_q == S_MAC_OWN);
    mac_ctrl.clear  = accept && (corner_i == CORNER_ORIGIN);
    mac_ctrl.corner = (state_q == S_MAC_FIRST) ? CORNER_ORIGIN : corner_q;
    mac_disp        = (state_q == S_MAC_FIRST) ? fcs_q : disp_q;
  end

  // control and cell state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        query_q[i]  <= '0;
        origin_q[i] <= '0;
        fcs_q[i]    <= '0;
        weight_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      bad_q       <= bad_d;
      weight_q    <= weight_d;
      out_valid_q <= (state_q == S_OUT);
      if (accept && corner_i == CORNER_ORIGIN) begin
        query_q  <= query_in;
        origin_q <= rest_in;
        fcs_q    <= disp_in;
      end
    end
  end

  // per-item operands and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      corner_q <= corner_i;
      disp_q   <= disp_in;
      h_q      <= {rest_z_i[COORD_W-1], rest_z_i}
                - {origin_q[2][COORD_W-1], origin_q[2]};
    end
    if (state_q == S_OUT) begin
      for (int i = 0; i < AXES; i++) begin
        out_q[i] <= sat_coord(out_wide[i]);
      end
      out_bad_q <= bad_q;
    end
  end

  // query plus accumulated displacement
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      out_wide[i] = {{(SUM_W+1-COORD_W){query_q[i][COORD_W-1]}}, query_q[i]}
                  + {sum[i][SUM_W-1], sum[i]};
    end
  end

  hctd_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .num_i  (d_axis[COORD_W-1:0]),
    .den_i  (h_q[COORD_W-1:0]),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  hctd_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .disp_i  (mac_disp),
    .weight_i(weight_q),
    .done_o  (mac_done),
    .sum_o   (sum)
  );

  assign busy         = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign degenerate_o = out_bad_q;

  // checks
  `HCTD_ASSERT_NEXT(a_result_follows_out, state_q == S_OUT, out_valid_o, "result strobe missing after corner 7")
  `HCTD_ASSERT_NOW(a_result_source, out_valid_o, $past(state_q) == S_OUT, "result strobe without corner 7")
  `HCTD_ASSERT_NOW(a_weight_range, 1'b1, (weight_q[0] <= ONE_W) && (weight_q[1] <= ONE_W) && (weight_q[2] <= ONE_W), "axis weight above one")
  `HCTD_ASSERT_NOW(a_div_done_state, div_done, state_q == S_DIV, "divider finished outside its wait state")
  `HCTD_ASSERT_NOW(a_mac_done_state, mac_done, (state_q == S_WAIT_FIRST) || (state_q == S_WAIT_OWN), "multiplier finished outside its wait state")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for the hexahedral cell trilinear displacement unit
`timescale 1ns / 1ps

module tb;
  import hctd_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE_W = longint'(1) << FRAC;
  localparam logic [FRAC:0] WEIGHT_ONE = (FRAC+1)'(ONE_W);
  localparam longint SUM_HI = (longint'(1) << 47) - 1;
  localparam longint SUM_LO = -(longint'(1) << 47);
  localparam longint COORD_HI = 64'sh7fff_ffff;
  localparam longint COORD_LO = -64'sh8000_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int CELLS_PER_PHASE = 26;

  // one corner item plus how the sender treats it
  typedef struct {
    logic [2:0]  corner;
    coord_t      query_x, query_y, query_z;
    coord_t      rest_x, rest_y, rest_z;
    coord_t      moved_x, moved_y, moved_z;
    int unsigned gap_pct;
    bit          drain_first;
  } corner_item_t;

  // one moved query point
  typedef struct {
    coord_t x, y, z;
    logic   degenerate;
  } moved_point_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  logic [2:0] corner_i = '0;
  coord_t query_x_i = '0, query_y_i = '0, query_z_i = '0;
  coord_t rest_x_i = '0, rest_y_i = '0, rest_z_i = '0;
  coord_t moved_x_i = '0, moved_y_i = '0, moved_z_i = '0;
  logic   out_valid_o;
  coord_t out_x_o, out_y_o, out_z_o;
  logic   degenerate_o;

  corner_item_t corner_feed[$];
  corner_item_t in_flight;
  moved_point_t expected_moves[$];
  moved_point_t moved_want;
  int mismatches = 0;
  int cycle_count = 0;

  // predicted cell state
  longint pt_query[3];
  longint pt_origin[3];
  longint pt_shift0[3];
  longint pt_acc[3];
  longint corner_disp[3];
  logic [FRAC:0] pt_weight[3];
  logic pt_bad;

  hex_cell_trilinear_displacement_unit #(.FRAC_BITS(FRAC)) u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // weighted displacement of one corner into the running sums
  function automatic void add_weighted(input logic [2:0] c, input bit from_origin);
    longint f[3];
    longint cw;
    longint part;
    longint d;
    for (int i = 0; i < 3; i++) begin
      f[i] = c[2-i] ? longint'(pt_weight[i]) : ONE_W - longint'(pt_weight[i]);
    end
    cw = (f[0] * f[1]) >>> FRAC;
    cw = (cw * f[2]) >>> FRAC;
    for (int i = 0; i < 3; i++) begin
      d = from_origin ? pt_shift0[i] : corner_disp[i];
      part = (d * cw) >>> FRAC;
      pt_acc[i] = clip(pt_acc[i] + part, SUM_LO, SUM_HI);
    end
  endfunction

  // advance the predicted state by one accepted item
  function automatic void predict_corner(input corner_item_t it);
    longint rest_v[3];
    longint moved_v[3];
    longint q_v[3];
    longint h;
    longint dd;
    moved_point_t r;
    rest_v[0] = it.rest_x;   rest_v[1] = it.rest_y;   rest_v[2] = it.rest_z;
    moved_v[0] = it.moved_x; moved_v[1] = it.moved_y; moved_v[2] = it.moved_z;
    q_v[0] = it.query_x;     q_v[1] = it.query_y;     q_v[2] = it.query_z;
    for (int i = 0; i < 3; i++) begin
      corner_disp[i] = clip(moved_v[i] - rest_v[i], COORD_LO, COORD_HI);
    end
    if (it.corner == CORNER_ORIGIN) begin
      for (int i = 0; i < 3; i++) begin
        pt_query[i] = q_v[i];
        pt_origin[i] = rest_v[i];
        pt_shift0[i] = corner_disp[i];
        pt_weight[i] = '0;
        pt_acc[i] = 0;
      end
      pt_bad = 1'b0;
    end else begin
      // edge corner sets the weights and folds in corner 0
      if (it.corner == CORNER_EDGE) begin
        h = rest_v[2] - pt_origin[2];
        pt_bad = (h <= 0);
        for (int i = 0; i < 3; i++) begin
          dd = pt_query[i] - pt_origin[i];
          if (h <= 0 || dd <= 0) begin
            pt_weight[i] = '0;
          end else if (dd >= h) begin
            pt_weight[i] = WEIGHT_ONE;
          end else begin
            pt_weight[i] = (FRAC+1)'((dd <<< FRAC) / h);
          end
        end
        add_weighted(CORNER_ORIGIN, 1'b1);
      end
      add_weighted(it.corner, 1'b0);
      if (it.corner == CORNER_LAST) begin
        r.x = coord_t'(clip(pt_query[0] + pt_acc[0], COORD_LO, COORD_HI));
        r.y = coord_t'(clip(pt_query[1] + pt_acc[1], COORD_LO, COORD_HI));
        r.z = coord_t'(clip(pt_query[2] + pt_acc[2], COORD_LO, COORD_HI));
        r.degenerate = pt_bad;
        expected_moves = {expected_moves, r};
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h", field, cycle_count, got,
             want);
    mismatches++;
  endtask

  task automatic push_corner(input logic [2:0] c, input coord_t qx, input coord_t qy,
                             input coord_t qz, input coord_t rx, input coord_t ry,
                             input coord_t rz, input coord_t mx, input coord_t my,
                             input coord_t mz, input int unsigned gap, input bit drain);
    corner_item_t it;
    it.corner = c;
    it.query_x = qx; it.query_y = qy; it.query_z = qz;
    it.rest_x = rx;  it.rest_y = ry;  it.rest_z = rz;
    it.moved_x = mx; it.moved_y = my; it.moved_z = mz;
    it.gap_pct = gap;
    it.drain_first = drain;
    corner_feed = {corner_feed, it};
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  // one cell of eight corners, mostly well formed, at times after a stray item
  task automatic queue_cell(input int unsigned gap, input bit drain);
    longint org[3];
    longint offs[3];
    longint span;
    longint h;
    longint shift;
    coord_t rv[3];
    coord_t mv[3];
    logic [2:0] c;
    bit broken;
    int unsigned mode;
    for (int i = 0; i < 3; i++) begin
      org[i] = ($urandom_range(0, 4) == 0) ? longint'(any_coord())
                                           : longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    // edge length: sometimes not positive, sometimes huge
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      h = 0;
    end else if (mode == 1) begin
      h = -longint'($urandom_range(1, 32'h7fff_ffff));
    end else if (mode == 2) begin
      h = longint'($urandom_range(1, 32'h7fff_ffff));
    end else begin
      h = longint'($urandom_range(1, 1 << 20));
    end
    span = (h > 0) ? h : (1 << 16);
    // query below, above or inside the cell per axis
    for (int i = 0; i < 3; i++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        offs[i] = -longint'($urandom_range(0, 32'(span)));
      end else if (mode == 1) begin
        offs[i] = h + longint'($urandom_range(0, 32'(span)));
      end else begin
        offs[i] = longint'($urandom_range(1, 32'(span - 1)));
      end
    end
    broken = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 11) == 0) begin
      push_corner(3'($urandom_range(0, 7)), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), gap, 1'b0);
    end
    for (int k = 0; k < 8; k++) begin
      c = (broken && $urandom_range(0, 1)) ? 3'($urandom_range(0, 7)) : 3'(k);
      for (int i = 0; i < 3; i++) begin
        rv[i] = coord_t'(org[i] + (c[2-i] ? h : 0));
        shift = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
        mv[i] = ($urandom_range(0, 7) == 0) ? any_coord() : coord_t'(longint'(rv[i]) + shift);
      end
      if (c == CORNER_ORIGIN) begin
        push_corner(c, coord_t'(org[0] + offs[0]), coord_t'(org[1] + offs[1]),
                    coord_t'(org[2] + offs[2]), rv[0], rv[1], rv[2], mv[0], mv[1], mv[2],
                    gap, drain && k == 0);
      end else begin
        push_corner(c, any_coord(), any_coord(), any_coord(), rv[0], rv[1], rv[2],
                    mv[0], mv[1], mv[2], gap, drain && k == 0);
      end
    end
  endtask

  // driver: holds each item until the handshake takes it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_corner(in_flight);
      end
      if (!start || !busy) begin
        if (corner_feed.size() != 0 &&
            !(corner_feed[0].drain_first && expected_moves.size() != 0) &&
            $urandom_range(0, 99) >= corner_feed[0].gap_pct) begin
          in_flight = corner_feed.pop_front();
          start <= 1'b1;
          corner_i <= in_flight.corner;
          query_x_i <= in_flight.query_x;
          query_y_i <= in_flight.query_y;
          query_z_i <= in_flight.query_z;
          rest_x_i <= in_flight.rest_x;
          rest_y_i <= in_flight.rest_y;
          rest_z_i <= in_flight.rest_z;
          moved_x_i <= in_flight.moved_x;
          moved_y_i <= in_flight.moved_y;
          moved_z_i <= in_flight.moved_z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (expected_moves.size() == 0) begin
        report_mismatch("unexpected result", longint'(out_x_o), 0);
      end else begin
        moved_want = expected_moves.pop_front();
        if (out_x_o !== moved_want.x) report_mismatch("out_x", out_x_o, moved_want.x);
        if (out_y_o !== moved_want.y) report_mismatch("out_y", out_y_o, moved_want.y);
        if (out_z_o !== moved_want.z) report_mismatch("out_z", out_z_o, moved_want.z);
        if (degenerate_o !== moved_want.degenerate) begin
          report_mismatch("degenerate", degenerate_o, moved_want.degenerate);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hex_cell_trilinear_displacement_unit test failed");
      $finish;
    end
  end

  initial begin
    // last corner straight after reset, everything still zero
    push_corner(CORNER_LAST, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 30, 1'b0);
    // origin then last corner with no edge corner between
    push_corner(CORNER_ORIGIN, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0,
                32'sh7fff_ffff, 32'sh0, 32'sh8000_0000,
                32'sh8000_0000, 32'sh1234, 32'sh7fff_ffff, 30, 1'b0);
    push_corner(CORNER_LAST, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                32'sh0001_0000, 32'sh0, 32'sh0, 30, 1'b0);
    // unit cell: x on the low face, y past the high face, z a quarter in
    for (int k = 0; k < 8; k++) begin
      push_corner(3'(k), (k == 0) ? 32'sh0 : any_coord(), 32'sh0002_0000, 32'sh0000_4000,
                  k[2] ? 32'sh0001_0000 : 32'sh0, k[1] ? 32'sh0001_0000 : 32'sh0,
                  k[0] ? 32'sh0001_0000 : 32'sh0,
                  (k == 0) ? 32'sh7fff_ffff : 32'sh0000_8000,
                  (k == 3) ? 32'sh8000_0000 : 32'sh0000_0100,
                  (k == 2) ? 32'sh7fff_ffff : 32'sh0,
                  (k == 0) ? 0 : 30, k == 0);
    end
    // negative edge: corner 0 carries the full weight
    for (int k = 0; k < 8; k++) begin
      push_corner(3'(k), 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0,
                  32'sh8000_0000, 32'sh7fff_ffff, (k == 1) ? 32'sh8000_0000 : 32'sh0001_0000,
                  32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0040, 0, k == 0);
    end
    // zero edge
    push_corner(CORNER_ORIGIN, 32'sh10, 32'sh20, 32'sh30, 32'sh5, 32'sh5, 32'sh5,
                32'sh6, 32'sh7, 32'sh8, 0, 1'b1);
    push_corner(CORNER_EDGE, 32'sh0, 32'sh0, 32'sh0, 32'sh5, 32'sh5, 32'sh5,
                32'sh9, 32'sh9, 32'sh9, 0, 1'b0);
    push_corner(CORNER_LAST, 32'sh0, 32'sh0, 32'sh0, 32'sh5, 32'sh5, 32'sh5,
                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1'b0);
    // random cells: no idling, heavy sender idling, no idling again, light sender idling
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        queue_cell((p == 1) ? 70 : ((p == 3) ? 21 : 0), n == 0);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every item to go in and every result to come out
    while (corner_feed.size() != 0 || start) @(posedge clk_i);
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("hex_cell_trilinear_displacement_unit test passed");
    end else begin
      $display("hex_cell_trilinear_displacement_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hctd_pkg.sv
rtl/hctd_div.sv
rtl/hctd_mac.sv
rtl/hex_cell_trilinear_displacement_unit.sv
test/tb.sv
